// ----- hw/rtl/elfm_pkg.sv -----
package elfm_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [2:0][31:0]  vec3_t;
  typedef logic [2:0][63:0]  wvec3_t;

  localparam int unsigned DIV_W = 64;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
  localparam logic signed [65:0] HALF_Q30 = 66'sd536870912;

  localparam logic [2:0] MODE_X   = 3'd0;
  localparam logic [2:0] MODE_Y   = 3'd1;
  localparam logic [2:0] MODE_Z   = 3'd2;
  localparam logic [2:0] MODE_XY  = 3'd3;
  localparam logic [2:0] MODE_XZ  = 3'd4;
  localparam logic [2:0] MODE_YZ  = 3'd5;
  localparam logic [2:0] MODE_XYZ = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DEGEN    = 2'd1;
  localparam logic [1:0] ST_TOO_MANY = 2'd2;
  localparam logic [1:0] ST_BAD_DIM  = 2'd3;

  localparam logic [0:0] REG_COORD_MODE = 1'b0;
  localparam logic [0:0] REG_ELEM_DIM   = 1'b1;

  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_LD_RD    = 19'h00002,
    S_LD_CAP   = 19'h00004,
    S_FR_GO    = 19'h00008,
    S_NM_INIT  = 19'h00010,
    S_NM_SHIFT = 19'h00020,
    S_NM_SQ    = 19'h00040,
    S_NM_X0    = 19'h00080,
    S_NM_NDIV  = 19'h00100,
    S_NM_NWAIT = 19'h00200,
    S_NM_UDIV  = 19'h00400,
    S_NM_UWAIT = 19'h00800,
    S_FR_NEXT  = 19'h01000,
    S_CROSS    = 19'h02000,
    S_RD       = 19'h04000,
    S_OUT_LD   = 19'h08000,
    S_OUT_MAC  = 19'h10000,
    S_OUT_EMIT = 19'h20000,
    S_EQ_EMIT  = 19'h40000
  } state_t;

  // which frame vector the running normalisation produces
  typedef enum logic [3:0] {
    PH_X = 4'b0001,
    PH_H = 4'b0010,
    PH_Z = 4'b0100,
    PH_Y = 4'b1000
  } phase_t;

  function automatic logic [1:0] sys_dim(input logic [2:0] mode);
    logic [1:0] d;
    unique case (mode)
      MODE_X, MODE_Y, MODE_Z:    d = 2'd1;
      MODE_XY, MODE_XZ, MODE_YZ: d = 2'd2;
      MODE_XYZ:                  d = 2'd3;
      default:                   d = 2'd0;
    endcase
    return d;
  endfunction

  function automatic vec3_t perm(input logic [2:0] mode, input vec3_t v);
    vec3_t p;
    p = v;
    unique case (mode)
      MODE_Y:  begin p[0] = v[1]; p[1] = v[0]; end
      MODE_Z:  begin p[0] = v[2]; p[2] = v[0]; end
      MODE_XZ: begin p[1] = v[2]; p[2] = v[1]; end
      MODE_YZ: begin p[0] = v[1]; p[1] = v[2]; p[2] = v[0]; end
      default: p = v;
    endcase
    return p;
  endfunction

  function automatic logic signed [65:0] sx66(input logic [31:0] a);
    return {{34{a[31]}}, a};
  endfunction

  function automatic word_t sat32(input logic signed [65:0] v);
    word_t r;
    if (v > S32_MAX) r = 32'h7FFF_FFFF;
    else if (v < S32_MIN) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [63:0] max3(input wvec3_t m);
    logic [63:0] r;
    r = m[0];
    if (m[1] > r) r = m[1];
    if (m[2] > r) r = m[2];
    return r;
  endfunction

  // helper for a 3D line: axis vector when u lies on one axis, else u with first nonzero flipped
  function automatic vec3_t helper_vec(input vec3_t u);
    vec3_t h;
    logic nz0, nz1, nz2;
    nz0 = (u[0] != '0);
    nz1 = (u[1] != '0);
    nz2 = (u[2] != '0);
    h = u;
    priority if (nz0 && !nz1 && !nz2) begin
      h = '0;
      h[2] = ONE_Q30;
    end else if (nz1 && !nz0 && !nz2) begin
      h = '0;
      h[0] = ONE_Q30;
    end else if (nz2 && !nz0 && !nz1) begin
      h = '0;
      h[1] = ONE_Q30;
    end else if (nz0) begin
      h[0] = ~u[0] + 32'd1;
    end else if (nz1) begin
      h[1] = ~u[1] + 32'd1;
    end else if (nz2) begin
      h[2] = ~u[2] + 32'd1;
    end else begin
      h = u;
    end
    return h;
  endfunction

endpackage

// ----- hw/rtl/elfm_ram.sv -----
module elfm_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/elfm_div.sv -----
module elfm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [elfm_pkg::DIV_W-1:0]  dividend,
  input  logic [elfm_pkg::DIV_W-1:0]  divisor,
  output logic                        done,
  output logic [elfm_pkg::DIV_W-1:0]  quotient
);

  localparam int DW = elfm_pkg::DIV_W;
  localparam int KW = $clog2(DW);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [DW:0]   trial;
  logic          fits;

  // restoring, one quotient bit a cycle
  assign trial = {rem_r, dvd_r[DW-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      dvd_nxt = dividend;
      dvs_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = fits ? DW'(trial - {1'b0, dvs_r}) : trial[DW-1:0];
      dvd_nxt = {dvd_r[DW-2:0], fits};
      cnt_nxt = cnt_r + KW'(1);
      if (cnt_r == KW'(DW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ----- hw/rtl/element_local_frame_mapper.sv -----
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------------
// input     | start, busy          | in_node_x/y/z (Q16.16), in_last_node
// result    | out_valid (strobe)   | out_local_x/y/z, out_last_result, out_map_status
// config    | cfg_wr_en            | cfg_index, cfg_data
//
// A non-last node word is stored while idle if the store has room. A last node with an error
// status gives its single result in the next cycle. Same dimensions: each node is read back and
// emitted in permuted axis order. Otherwise the frame is built on one 32x32 multiplier and a
// 64-bit radix-2 divider: RSQRT_ITERS Newton divisions and three component divisions per
// normalisation, one in 2D, three for a 3D line, four for a 3D plane; nodes are then mapped
// by multiply-accumulate. Reset is synchronous; no clearing pass. Results cannot be stalled.
module element_local_frame_mapper #(
  parameter int MAX_NODES   = 8,
  parameter int RSQRT_ITERS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic signed [31:0] in_node_x,
  input  logic signed [31:0] in_node_y,
  input  logic signed [31:0] in_node_z,
  input  logic              in_last_node,
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_index,
  input  logic [2:0]        cfg_data,
  output logic              out_valid,
  output logic signed [31:0] out_local_x,
  output logic signed [31:0] out_local_y,
  output logic signed [31:0] out_local_z,
  output logic              out_last_result,
  output logic [1:0]        out_map_status
);

  localparam int AW = $clog2(MAX_NODES > 1 ? MAX_NODES : 2);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int IW = $clog2(RSQRT_ITERS + 1);

  elfm_pkg::state_t state_r, state_nxt;
  elfm_pkg::phase_t phase_r, phase_nxt;

  logic [2:0]    coord_mode_r;
  logic [1:0]    elem_dim_r;
  logic [CW-1:0] nodes_r, nodes_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          eq_r, eq_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [IW-1:0] it_r, it_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [1:0]    cc_r, cc_nxt;
  logic [1:0]    rr_r, rr_nxt;
  logic          ov_r, ov_nxt;

  elfm_pkg::vec3_t  p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  elfm_pkg::vec3_t  u_r, u_nxt, ux_r, ux_nxt, uh_r, uh_nxt, uz_r, uz_nxt;
  elfm_pkg::vec3_t  q_r, q_nxt, loc_r, loc_nxt;
  elfm_pkg::wvec3_t w_r, w_nxt, mag_r, mag_nxt;
  logic [2:0]       neg_r, neg_nxt;
  logic [63:0]      s_r, s_nxt, x_r, x_nxt;
  logic [8:0][31:0] rot_r, rot_nxt;
  logic signed [65:0] acc_r, acc_nxt;
  logic signed [63:0] prod_r;
  logic [31:0]      ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic             olast_r, olast_nxt;
  logic [1:0]       ost_r, ost_nxt;

  logic [1:0]       sd, ed;
  logic             full;
  logic [CW-1:0]    need, lim;
  logic             ram_we;
  logic [95:0]      ram_rdata;
  elfm_pkg::vec3_t  rd_vec, trans, cra, crb;
  elfm_pkg::wvec3_t wmag;
  logic [63:0]      wmax, mmax;
  logic signed [31:0] mul_a, mul_b;
  logic             div_start, div_done;
  logic [63:0]      div_dvd, div_dvs, div_q;
  logic [64:0]      half;
  logic signed [65:0] accsum, rnd;
  logic [3:0]       rot_idx;
  logic [1:0]       ai, bi;
  logic             last_idx;

  assign sd   = elfm_pkg::sys_dim(coord_mode_r);
  assign ed   = elem_dim_r;
  assign full = (nodes_r == CW'(MAX_NODES));
  assign need = (sd == 2'd3 && ed == 2'd2) ? CW'(3) : CW'(2);
  assign lim  = (n_r < need) ? n_r : need;
  assign last_idx = (idx_r + CW'(1) == n_r);

  assign ram_we = (state_r == elfm_pkg::S_IDLE) && start && !full;

  elfm_ram #(
    .WIDTH(96),
    .DEPTH(MAX_NODES)
  ) u_node_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(nodes_r[AW-1:0]),
    .wdata({in_node_z, in_node_y, in_node_x}),
    .raddr(idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  elfm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quotient(div_q)
  );

  assign rd_vec = elfm_pkg::perm(coord_mode_r, ram_rdata);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trans[k] = elfm_pkg::sat32(elfm_pkg::sx66(rd_vec[k]) - elfm_pkg::sx66(p0_r[k]));
      wmag[k]  = w_r[k][63] ? (~w_r[k] + 64'd1) : w_r[k];
    end
  end

  assign wmax = elfm_pkg::max3(wmag);
  assign mmax = elfm_pkg::max3(mag_r);
  assign half = ({1'b0, x_r} + {1'b0, div_q}) >> 1;
  assign accsum = acc_r + {{2{prod_r[63]}}, prod_r};
  assign rnd = (accsum + elfm_pkg::HALF_Q30) >>> 30;
  assign rot_idx = {2'b00, rr_r} * 4'd3 + {2'b00, cc_r};
  assign cra = (phase_r == elfm_pkg::PH_Z) ? ux_r : uz_r;
  assign crb = (phase_r == elfm_pkg::PH_Z) ? uh_r : ux_r;

  always_comb begin
    unique case (cnt_r)
      3'd0:    begin ai = 2'd1; bi = 2'd2; end
      3'd1:    begin ai = 2'd2; bi = 2'd1; end
      3'd2:    begin ai = 2'd2; bi = 2'd0; end
      3'd3:    begin ai = 2'd0; bi = 2'd2; end
      3'd4:    begin ai = 2'd0; bi = 2'd1; end
      3'd5:    begin ai = 2'd1; bi = 2'd0; end
      default: begin ai = 2'd0; bi = 2'd0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    nodes_nxt = nodes_r;
    ovf_nxt   = ovf_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    eq_nxt    = eq_r;
    st_nxt    = st_r;
    it_nxt    = it_r;
    cnt_nxt   = cnt_r;
    cc_nxt    = cc_r;
    rr_nxt    = rr_r;
    ov_nxt    = 1'b0;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    u_nxt     = u_r;
    ux_nxt    = ux_r;
    uh_nxt    = uh_r;
    uz_nxt    = uz_r;
    q_nxt     = q_r;
    loc_nxt   = loc_r;
    w_nxt     = w_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    s_nxt     = s_r;
    x_nxt     = x_r;
    rot_nxt   = rot_r;
    acc_nxt   = acc_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    oz_nxt    = oz_r;
    olast_nxt = olast_r;
    ost_nxt   = ost_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = s_r;
    div_dvs   = x_r;

    unique case (state_r)
      elfm_pkg::S_IDLE: begin
        if (start) begin
          if (!full) nodes_nxt = nodes_r + CW'(1);
          if (!in_last_node) begin
            ovf_nxt = ovf_r | full;
          end else begin
            nodes_nxt = '0;
            ovf_nxt   = 1'b0;
            n_nxt     = full ? nodes_r : nodes_r + CW'(1);
            idx_nxt   = '0;
            ox_nxt    = '0;
            oy_nxt    = '0;
            oz_nxt    = '0;
            olast_nxt = 1'b1;
            priority if (ovf_r || full) begin
              ov_nxt  = 1'b1;
              ost_nxt = elfm_pkg::ST_TOO_MANY;
            end else if (sd == 2'd0 || ed == 2'd0 || ed > sd) begin
              ov_nxt  = 1'b1;
              ost_nxt = elfm_pkg::ST_BAD_DIM;
            end else if (ed == sd) begin
              eq_nxt    = 1'b1;
              state_nxt = elfm_pkg::S_RD;
            end else begin
              eq_nxt    = 1'b0;
              state_nxt = elfm_pkg::S_LD_RD;
            end
          end
        end
      end

      elfm_pkg::S_LD_RD: state_nxt = elfm_pkg::S_LD_CAP;

      elfm_pkg::S_LD_CAP: begin
        if (idx_r == '0) p0_nxt = rd_vec;
        else if (idx_r == CW'(1)) p1_nxt = trans;
        else p2_nxt = trans;
        if (idx_r + CW'(1) == lim) begin
          if (lim < need) begin
            // too few nodes for a frame: identity rotation
            rot_nxt    = '0;
            rot_nxt[0] = elfm_pkg::ONE_Q30;
            rot_nxt[4] = elfm_pkg::ONE_Q30;
            rot_nxt[8] = elfm_pkg::ONE_Q30;
            st_nxt     = elfm_pkg::ST_DEGEN;
            idx_nxt    = '0;
            state_nxt  = elfm_pkg::S_RD;
          end else begin
            state_nxt = elfm_pkg::S_FR_GO;
          end
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = elfm_pkg::S_LD_RD;
        end
      end

      elfm_pkg::S_FR_GO: begin
        w_nxt[0]  = 64'(elfm_pkg::sx66(p1_r[0]));
        w_nxt[1]  = 64'(elfm_pkg::sx66(p1_r[1]));
        w_nxt[2]  = (sd == 2'd2) ? 64'd0 : 64'(elfm_pkg::sx66(p1_r[2]));
        phase_nxt = elfm_pkg::PH_X;
        state_nxt = elfm_pkg::S_NM_INIT;
      end

      elfm_pkg::S_NM_INIT: begin
        if (wmax == '0) begin
          rot_nxt    = '0;
          rot_nxt[0] = elfm_pkg::ONE_Q30;
          rot_nxt[4] = elfm_pkg::ONE_Q30;
          rot_nxt[8] = elfm_pkg::ONE_Q30;
          st_nxt     = elfm_pkg::ST_DEGEN;
          idx_nxt    = '0;
          state_nxt  = elfm_pkg::S_RD;
        end else begin
          mag_nxt   = wmag;
          for (int k = 0; k < 3; k++) neg_nxt[k] = w_r[k][63];
          state_nxt = elfm_pkg::S_NM_SHIFT;
        end
      end

      // bring the largest magnitude into [2^29, 2^30), one bit a cycle
      elfm_pkg::S_NM_SHIFT: begin
        priority if (mmax >= 64'h4000_0000) begin
          for (int k = 0; k < 3; k++) mag_nxt[k] = mag_r[k] >> 1;
        end else if (mmax < 64'h2000_0000) begin
          for (int k = 0; k < 3; k++) mag_nxt[k] = mag_r[k] << 1;
        end else begin
          cnt_nxt   = '0;
          s_nxt     = '0;
          state_nxt = elfm_pkg::S_NM_SQ;
        end
      end

      elfm_pkg::S_NM_SQ: begin
        if (cnt_r < 3'd3) begin
          mul_a = mag_r[cnt_r[1:0]][31:0];
          mul_b = mag_r[cnt_r[1:0]][31:0];
        end
        if (cnt_r != 3'd0) s_nxt = s_r + prod_r;
        if (cnt_r == 3'd3) state_nxt = elfm_pkg::S_NM_X0;
        else cnt_nxt = cnt_r + 3'd1;
      end

      // sum of squares lies in [2^58, 2^62)
      elfm_pkg::S_NM_X0: begin
        x_nxt     = (s_r[61] || s_r[60]) ? 64'h8000_0000 : 64'h4000_0000;
        it_nxt    = '0;
        state_nxt = elfm_pkg::S_NM_NDIV;
      end

      elfm_pkg::S_NM_NDIV: begin
        div_start = 1'b1;
        state_nxt = elfm_pkg::S_NM_NWAIT;
      end

      elfm_pkg::S_NM_NWAIT: begin
        if (div_done) begin
          x_nxt  = (half == '0) ? 64'd1 : half[63:0];
          it_nxt = it_r + IW'(1);
          if (it_r + IW'(1) == IW'(RSQRT_ITERS)) begin
            cnt_nxt   = '0;
            state_nxt = elfm_pkg::S_NM_UDIV;
          end else begin
            state_nxt = elfm_pkg::S_NM_NDIV;
          end
        end
      end

      elfm_pkg::S_NM_UDIV: begin
        div_start = 1'b1;
        div_dvd   = {mag_r[cnt_r[1:0]][33:0], 30'd0};
        state_nxt = elfm_pkg::S_NM_UWAIT;
      end

      elfm_pkg::S_NM_UWAIT: begin
        div_dvd = {mag_r[cnt_r[1:0]][33:0], 30'd0};
        if (div_done) begin
          u_nxt[cnt_r[1:0]] = elfm_pkg::sat32(neg_r[cnt_r[1:0]] ? -$signed({2'b00, div_q})
                                                              : $signed({2'b00, div_q}));
          if (cnt_r == 3'd2) begin
            state_nxt = elfm_pkg::S_FR_NEXT;
          end else begin
            cnt_nxt   = cnt_r + 3'd1;
            state_nxt = elfm_pkg::S_NM_UDIV;
          end
        end
      end

      elfm_pkg::S_FR_NEXT: begin
        cnt_nxt = '0;
        unique case (phase_r)
          elfm_pkg::PH_X: begin
            ux_nxt = u_r;
            priority if (sd == 2'd2) begin
              rot_nxt    = '0;
              rot_nxt[0] = u_r[0];
              rot_nxt[1] = ~u_r[1] + 32'd1;
              rot_nxt[3] = u_r[1];
              rot_nxt[4] = u_r[0];
              st_nxt     = elfm_pkg::ST_OK;
              idx_nxt    = '0;
              state_nxt  = elfm_pkg::S_RD;
            end else if (ed == 2'd2) begin
              for (int k = 0; k < 3; k++)
                w_nxt[k] = 64'(elfm_pkg::sx66(p2_r[k]) - elfm_pkg::sx66(p1_r[k]));
              phase_nxt = elfm_pkg::PH_H;
              state_nxt = elfm_pkg::S_NM_INIT;
            end else begin
              uh_nxt    = elfm_pkg::helper_vec(u_r);
              phase_nxt = elfm_pkg::PH_Z;
              state_nxt = elfm_pkg::S_CROSS;
            end
          end
          elfm_pkg::PH_H: begin
            uh_nxt    = u_r;
            phase_nxt = elfm_pkg::PH_Z;
            state_nxt = elfm_pkg::S_CROSS;
          end
          elfm_pkg::PH_Z: begin
            uz_nxt    = u_r;
            phase_nxt = elfm_pkg::PH_Y;
            state_nxt = elfm_pkg::S_CROSS;
          end
          elfm_pkg::PH_Y: begin
            for (int k = 0; k < 3; k++) begin
              rot_nxt[k*3]   = ux_r[k];
              rot_nxt[k*3+1] = u_r[k];
              rot_nxt[k*3+2] = uz_r[k];
            end
            st_nxt    = elfm_pkg::ST_OK;
            idx_nxt   = '0;
            state_nxt = elfm_pkg::S_RD;
          end
          default: state_nxt = elfm_pkg::S_IDLE;
        endcase
      end

      // six products, each folded in the cycle after it is registered
      elfm_pkg::S_CROSS: begin
        if (cnt_r < 3'd6) begin
          mul_a = cra[ai];
          mul_b = crb[bi];
        end
        if (cnt_r != 3'd0) begin
          if (cnt_r[0]) w_nxt[2'((cnt_r - 3'd1) >> 1)] = prod_r;
          else w_nxt[2'((cnt_r - 3'd1) >> 1)] = w_r[2'((cnt_r - 3'd1) >> 1)] - prod_r;
        end
        if (cnt_r == 3'd6) state_nxt = elfm_pkg::S_NM_INIT;
        else cnt_nxt = cnt_r + 3'd1;
      end

      elfm_pkg::S_RD: state_nxt = eq_r ? elfm_pkg::S_EQ_EMIT : elfm_pkg::S_OUT_LD;

      elfm_pkg::S_EQ_EMIT: begin
        ov_nxt    = 1'b1;
        ox_nxt    = rd_vec[0];
        oy_nxt    = rd_vec[1];
        oz_nxt    = rd_vec[2];
        olast_nxt = last_idx;
        ost_nxt   = elfm_pkg::ST_OK;
        if (last_idx) begin
          state_nxt = elfm_pkg::S_IDLE;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = elfm_pkg::S_RD;
        end
      end

      elfm_pkg::S_OUT_LD: begin
        q_nxt     = trans;
        loc_nxt   = '0;
        acc_nxt   = '0;
        cc_nxt    = '0;
        rr_nxt    = '0;
        state_nxt = elfm_pkg::S_OUT_MAC;
      end

      elfm_pkg::S_OUT_MAC: begin
        if (rr_r < sd) begin
          mul_a = rot_r[rot_idx];
          mul_b = q_r[rr_r];
        end
        if (rr_r == sd) begin
          loc_nxt[cc_r] = elfm_pkg::sat32(rnd);
          acc_nxt       = '0;
          rr_nxt        = '0;
          if (cc_r + 2'd1 == sd) state_nxt = elfm_pkg::S_OUT_EMIT;
          else cc_nxt = cc_r + 2'd1;
        end else begin
          if (rr_r != 2'd0) acc_nxt = accsum;
          rr_nxt = rr_r + 2'd1;
        end
      end

      elfm_pkg::S_OUT_EMIT: begin
        ov_nxt    = 1'b1;
        ox_nxt    = loc_r[0];
        oy_nxt    = loc_r[1];
        oz_nxt    = loc_r[2];
        olast_nxt = last_idx;
        ost_nxt   = st_r;
        if (last_idx) begin
          state_nxt = elfm_pkg::S_IDLE;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = elfm_pkg::S_RD;
        end
      end

      default: state_nxt = elfm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= elfm_pkg::S_IDLE;
      phase_r      <= elfm_pkg::PH_X;
      coord_mode_r <= elfm_pkg::MODE_XYZ;
      elem_dim_r   <= 2'd2;
      nodes_r      <= '0;
      ovf_r        <= 1'b0;
      n_r          <= '0;
      idx_r        <= '0;
      eq_r         <= 1'b0;
      st_r         <= elfm_pkg::ST_OK;
      it_r         <= '0;
      cnt_r        <= '0;
      cc_r         <= '0;
      rr_r         <= '0;
      ov_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      nodes_r <= nodes_nxt;
      ovf_r   <= ovf_nxt;
      n_r     <= n_nxt;
      idx_r   <= idx_nxt;
      eq_r    <= eq_nxt;
      st_r    <= st_nxt;
      it_r    <= it_nxt;
      cnt_r   <= cnt_nxt;
      cc_r    <= cc_nxt;
      rr_r    <= rr_nxt;
      ov_r    <= ov_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          elfm_pkg::REG_COORD_MODE: coord_mode_r <= cfg_data;
          elfm_pkg::REG_ELEM_DIM:   elem_dim_r   <= cfg_data[1:0];
          default:                  coord_mode_r <= coord_mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p0_r    <= p0_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    u_r     <= u_nxt;
    ux_r    <= ux_nxt;
    uh_r    <= uh_nxt;
    uz_r    <= uz_nxt;
    q_r     <= q_nxt;
    loc_r   <= loc_nxt;
    w_r     <= w_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    s_r     <= s_nxt;
    x_r     <= x_nxt;
    rot_r   <= rot_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= mul_a * mul_b;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    oz_r    <= oz_nxt;
    olast_r <= olast_nxt;
    ost_r   <= ost_nxt;
  end

  assign busy            = (state_r != elfm_pkg::S_IDLE);
  assign out_valid       = ov_r;
  assign out_local_x     = ox_r;
  assign out_local_y     = oy_r;
  assign out_local_z     = oz_r;
  assign out_last_result = olast_r;
  assign out_map_status  = ost_r;

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_map_status == elfm_pkg::ST_TOO_MANY ||
                   out_map_status == elfm_pkg::ST_BAD_DIM)) |-> out_last_result)
    else $error("error word not marked last");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_r <= CW'(MAX_NODES))
    else $error("node count past store depth");

  a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == elfm_pkg::S_NM_NWAIT || state_r == elfm_pkg::S_NM_UWAIT))
    else $error("divider finished with nobody waiting");

  a_end_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_last_result))
    else $error("element finished without last word");

endmodule

// ----- verif/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_CAP   = 8;
  localparam int NEWTON_N   = 4;
  localparam int CYCLE_CAP  = 3000000;

  // no system type has this code
  localparam bit [2:0] MODE_NONE = 3'd7;

  typedef int     ivec_t[3];
  typedef longint lvec_t[3];

  typedef struct {
    int       x;
    int       y;
    int       z;
    bit       last;
    bit [1:0] status;
  } mapped_t;

  class frame_scoreboard;
    int       node_mem[NODE_CAP][3];
    int       rot[3][3];
    int       loaded;
    bit       spilled;
    bit [2:0] mode;
    bit [1:0] dim;
    mapped_t  pending[$];
    int       errors;
    int       checked;
    int       elements;

    function new();
      loaded = 0;
      spilled = 0;
      mode = elfm_pkg::MODE_XYZ;
      dim = 2'd2;
      errors = 0;
      checked = 0;
      elements = 0;
    endfunction

    function void set_reg(bit idx, bit [2:0] val);
      if (idx == elfm_pkg::REG_COORD_MODE) mode = val;
      else dim = val[1:0];
    endfunction

    function int clamp_q16(logic signed [65:0] v);
      if (v > elfm_pkg::S32_MAX) return 32'h7FFF_FFFF;
      if (v < elfm_pkg::S32_MIN) return 32'h8000_0000;
      return int'(v[31:0]);
    endfunction

    // scale into [2^29, 2^30), Newton length, divide back to Q2.30
    function bit unit_of(lvec_t v, output ivec_t u);
      logic [63:0] mag[3];
      logic [63:0] m, s, x, half, q;
      bit neg[3];
      int b;
      m = 0;
      s = 0;
      b = 0;
      u = '{0, 0, 0};
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i] < 0;
        mag[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) return 0;
      while (m >= (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        m = m >> 1;
      end
      while (m < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        m = m << 1;
      end
      for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
      for (int i = 0; i < 64; i++) if (s[i]) b = i;
      x = 64'd1 << ((b + 2) / 2);
      for (int i = 0; i < NEWTON_N; i++) begin
        half = (x + s / x) / 2;
        x = (half != 0) ? half : 64'd1;
      end
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] << 30) / x;
        u[i] = clamp_q16(neg[i] ? -66'(longint'(q)) : 66'(longint'(q)));
      end
      return 1;
    endfunction

    function lvec_t cross3(ivec_t a, ivec_t b);
      lvec_t r;
      r[0] = longint'(a[1]) * b[2] - longint'(a[2]) * b[1];
      r[1] = longint'(a[2]) * b[0] - longint'(a[0]) * b[2];
      r[2] = longint'(a[0]) * b[1] - longint'(a[1]) * b[0];
      return r;
    endfunction

    function bit build_rotation(int sd, int ed, int n, int p[NODE_CAP][3]);
      ivec_t ax, ay, az, h;
      lvec_t w;
      bit hit;
      if (n < 2 || (ed == 2 && n < 3)) return 0;
      if (sd == 2) begin
        w = '{p[1][0], p[1][1], 0};
        if (!unit_of(w, ax)) return 0;
        rot[0][0] = ax[0];
        rot[1][1] = ax[0];
        rot[0][1] = -ax[1];
        rot[1][0] = ax[1];
        return 1;
      end
      w = '{p[1][0], p[1][1], p[1][2]};
      if (!unit_of(w, ax)) return 0;
      if (ed == 2) begin
        for (int i = 0; i < 3; i++) w[i] = longint'(p[2][i]) - p[1][i];
        if (!unit_of(w, h)) return 0;
      end else begin
        h = '{0, 0, 0};
        if (ax[0] != 0 && ax[1] == 0 && ax[2] == 0) h[2] = elfm_pkg::ONE_Q30;
        else if (ax[1] != 0 && ax[0] == 0 && ax[2] == 0) h[0] = elfm_pkg::ONE_Q30;
        else if (ax[2] != 0 && ax[0] == 0 && ax[1] == 0) h[1] = elfm_pkg::ONE_Q30;
        else begin
          h = ax;
          hit = 0;
          for (int i = 0; i < 3; i++)
            if (!hit && ax[i] != 0) begin
              h[i] = -ax[i];
              hit = 1;
            end
        end
      end
      if (!unit_of(cross3(ax, h), az)) return 0;
      if (!unit_of(cross3(az, ax), ay)) return 0;
      for (int i = 0; i < 3; i++) begin
        rot[i][0] = ax[i];
        rot[i][1] = ay[i];
        rot[i][2] = az[i];
      end
      return 1;
    endfunction

    function void push_result(int x, int y, int z, bit last, bit [1:0] st);
      mapped_t e;
      e.x = x;
      e.y = y;
      e.z = z;
      e.last = last;
      e.status = st;
      pending = {pending, e};
    endfunction

    function void map_element();
      int p[NODE_CAP][3];
      int n, sd, ed, t, loc[3];
      bit [1:0] st;
      logic signed [65:0] acc;
      n = loaded;
      loaded = 0;
      ed = dim;
      st = elfm_pkg::ST_OK;
      elements++;
      sd = (mode <= elfm_pkg::MODE_Z) ? 1 : (mode <= elfm_pkg::MODE_YZ) ? 2 :
           (mode == elfm_pkg::MODE_XYZ) ? 3 : 0;
      if (spilled) begin
        spilled = 0;
        push_result(0, 0, 0, 1, elfm_pkg::ST_TOO_MANY);
        return;
      end
      if (sd == 0 || ed == 0 || ed > sd || n == 0) begin
        push_result(0, 0, 0, 1, elfm_pkg::ST_BAD_DIM);
        return;
      end
      for (int i = 0; i < n; i++) begin
        for (int c = 0; c < 3; c++) p[i][c] = node_mem[i][c];
        case (mode)
          elfm_pkg::MODE_Y:  begin t = p[i][0]; p[i][0] = p[i][1]; p[i][1] = t; end
          elfm_pkg::MODE_Z:  begin t = p[i][0]; p[i][0] = p[i][2]; p[i][2] = t; end
          elfm_pkg::MODE_XZ: begin t = p[i][1]; p[i][1] = p[i][2]; p[i][2] = t; end
          elfm_pkg::MODE_YZ: begin
            t = p[i][0];
            p[i][0] = p[i][1];
            p[i][1] = p[i][2];
            p[i][2] = t;
          end
          default: ;
        endcase
      end
      if (ed == sd) begin
        for (int i = 0; i < n; i++)
          push_result(p[i][0], p[i][1], p[i][2], i + 1 == n, elfm_pkg::ST_OK);
        return;
      end
      // node 0 last, so every node sees its original value
      for (int i = n - 1; i >= 0; i--)
        for (int c = 0; c < 3; c++)
          p[i][c] = clamp_q16(66'(longint'(p[i][c]) - p[0][c]));
      rot = '{default: 0};
      if (!build_rotation(sd, ed, n, p)) begin
        st = elfm_pkg::ST_DEGEN;
        rot = '{default: 0};
        for (int r = 0; r < sd; r++) rot[r][r] = elfm_pkg::ONE_Q30;
      end
      for (int i = 0; i < n; i++) begin
        for (int c = 0; c < 3; c++) begin
          loc[c] = 0;
          if (c < sd) begin
            acc = 0;
            for (int r = 0; r < sd; r++)
              acc += 66'(rot[r][c]) * 66'(p[i][r]);
            loc[c] = clamp_q16((acc + elfm_pkg::HALF_Q30) >>> 30);
          end
        end
        push_result(loc[0], loc[1], loc[2], i + 1 == n, st);
      end
    endfunction

    function void note_node(int x, int y, int z, bit last);
      if (loaded < NODE_CAP) begin
        node_mem[loaded] = '{x, y, z};
        loaded++;
      end else begin
        spilled = 1;
      end
      if (last) map_element();
    endfunction

    function void check(mapped_t got);
      mapped_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h last=%0d st=%0d", $time,
                 got.x, got.y, got.z, got.last, got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.x != e.x) begin
        $display("%0t: local_x expected %h actual %h", $time, e.x, got.x);
        errors++;
      end
      if (got.y != e.y) begin
        $display("%0t: local_y expected %h actual %h", $time, e.y, got.y);
        errors++;
      end
      if (got.z != e.z) begin
        $display("%0t: local_z expected %h actual %h", $time, e.z, got.z);
        errors++;
      end
      if (got.last != e.last) begin
        $display("%0t: last_result expected %0d actual %0d", $time, e.last, got.last);
        errors++;
      end
      if (got.status != e.status) begin
        $display("%0t: map_status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [31:0] in_node_x = 0;
  logic signed [31:0] in_node_y = 0;
  logic signed [31:0] in_node_z = 0;
  logic in_last_node = 0;
  logic cfg_wr_en = 0;
  logic [0:0] cfg_index = 0;
  logic [2:0] cfg_data = 0;
  logic out_valid;
  logic signed [31:0] out_local_x, out_local_y, out_local_z;
  logic out_last_result;
  logic [1:0] out_map_status;

  frame_scoreboard sb;
  int cycles = 0;
  int words_sent = 0;
  bit quiet = 0;

  element_local_frame_mapper #(.MAX_NODES(NODE_CAP), .RSQRT_ITERS(NEWTON_N)) uut (
    .clk, .rst_n, .start, .busy, .in_node_x, .in_node_y, .in_node_z, .in_last_node,
    .cfg_wr_en, .cfg_index, .cfg_data, .out_valid, .out_local_x, .out_local_y,
    .out_local_z, .out_last_result, .out_map_status
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    mapped_t got;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n) begin
      if (start && !busy) sb.note_node(in_node_x, in_node_y, in_node_z, in_last_node);
      if (out_valid) begin
        got.x = out_local_x;
        got.y = out_local_y;
        got.z = out_local_z;
        got.last = out_last_result;
        got.status = out_map_status;
        sb.check(got);
      end
    end
  end

  // drop start first so the last word is not taken again
  task automatic drain();
    @(negedge clk);
    start <= 0;
    do @(posedge clk); while (sb.pending.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, bit [2:0] val);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic set_frame(bit [2:0] m, bit [1:0] d);
    drain();
    write_reg(elfm_pkg::REG_COORD_MODE, m);
    write_reg(elfm_pkg::REG_ELEM_DIM, {1'b0, d});
  endtask

  task automatic send_word(int x, int y, int z, bit last);
    int gap;
    @(negedge clk);
    start <= 1;
    in_node_x <= x;
    in_node_y <= y;
    in_node_z <= z;
    in_last_node <= last;
    do @(posedge clk); while (busy);
    words_sent++;
    gap = 0;
    if (!quiet) begin
      if ($urandom_range(0, 11) == 0) gap = $urandom_range(8, 60);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      @(negedge clk);
      start <= 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic int rand_coord(int style);
    if (style == 0) return $urandom;
    return int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
  endfunction

  task automatic rand_element();
    int k, style, x, y, z;
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) k = 1;
    else if (r < 13) k = $urandom_range(9, 10);
    else k = $urandom_range(2, 6);
    style = ($urandom_range(0, 3) == 0) ? 0 : 1;
    x = rand_coord(style);
    y = rand_coord(style);
    z = rand_coord(style);
    for (int i = 0; i < k; i++) begin
      // now and then repeat the previous node to give a zero edge
      if (i == 0 || $urandom_range(0, 9) != 0) begin
        x = rand_coord(style);
        y = rand_coord(style);
        z = rand_coord(style);
      end
      send_word(x, y, z, i == k - 1);
    end
  endtask

  localparam bit [4:0] FRAMES[15] = '{
    {elfm_pkg::MODE_XYZ, 2'd2}, {elfm_pkg::MODE_XYZ, 2'd1}, {elfm_pkg::MODE_XY, 2'd1},
    {elfm_pkg::MODE_XZ, 2'd1},  {elfm_pkg::MODE_YZ, 2'd1},  {elfm_pkg::MODE_XYZ, 2'd1},
    {elfm_pkg::MODE_XYZ, 2'd2}, {elfm_pkg::MODE_X, 2'd1},   {elfm_pkg::MODE_Y, 2'd1},
    {elfm_pkg::MODE_Z, 2'd1},   {elfm_pkg::MODE_XYZ, 2'd3}, {elfm_pkg::MODE_XY, 2'd2},
    {MODE_NONE, 2'd2},          {elfm_pkg::MODE_XYZ, 2'd0}, {elfm_pkg::MODE_XY, 2'd3}
  };

  localparam int ONE_Q16 = 32'h0001_0000;
  localparam int POS_MAX = 32'h7FFF_FFFF;
  localparam int NEG_MAX = 32'h8000_0000;

  initial begin
    bit [4:0] f;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // plane, then a degenerate plane whose nodes are collinear
    set_frame(elfm_pkg::MODE_XYZ, 2'd2);
    send_word(0, 0, 0, 0);
    send_word(ONE_Q16, 0, 0, 0);
    send_word(0, ONE_Q16, 0, 1);
    send_word(0, 0, 0, 0);
    send_word(2 * ONE_Q16, 0, 0, 0);
    send_word(4 * ONE_Q16, 0, 0, 1);
    // 3D lines: extremes, each axis alone, single node, zero-length edge
    set_frame(elfm_pkg::MODE_XYZ, 2'd1);
    send_word(NEG_MAX, NEG_MAX, NEG_MAX, 0);
    send_word(POS_MAX, POS_MAX, POS_MAX, 1);
    send_word(0, 0, 0, 0);
    send_word(5 * ONE_Q16, 0, 0, 1);
    send_word(0, 0, 0, 0);
    send_word(0, -3 * ONE_Q16, 0, 1);
    send_word(0, 0, 0, 0);
    send_word(0, 0, 7 * ONE_Q16, 1);
    send_word(ONE_Q16, ONE_Q16, ONE_Q16, 1);
    send_word(-1, 2, 3, 0);
    send_word(-1, 2, 3, 1);
    // more nodes than the store holds
    for (int i = 0; i < 9; i++) send_word(i * ONE_Q16, -i, i, i == 8);
    set_frame(elfm_pkg::MODE_XYZ, 2'd3);
    send_word(POS_MAX, NEG_MAX, 0, 0);
    send_word(NEG_MAX, POS_MAX, -1, 1);
    set_frame(MODE_NONE, 2'd1);
    send_word(1, 2, 3, 1);
    set_frame(elfm_pkg::MODE_XY, 2'd3);
    send_word(1, 2, 3, 1);
    set_frame(elfm_pkg::MODE_XYZ, 2'd0);
    send_word(1, 2, 3, 1);

    while (words_sent < 200) begin
      f = FRAMES[$urandom_range(0, 14)];
      set_frame(f[4:2], f[1:0]);
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) rand_element();
    end
    quiet = 0;
    @(negedge clk);
    start <= 0;
    drain();
    repeat (50) @(posedge clk);

    $display("%0d node words, %0d elements, %0d results checked over all frame modes",
             words_sent, sb.elements, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/elfm_pkg.sv
hw/rtl/elfm_ram.sv
hw/rtl/elfm_div.sv
hw/rtl/element_local_frame_mapper.sv
verif/testbench.sv
